### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational check, sampled on every rising clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/u8vd_pkg.sv
package u8vd_pkg;

   // Ranges of the packed big-endian word, with the surrogate range that is rejected.
   localparam logic [31:0] ASCII_HI    = 32'h0000_007F;
   localparam logic [31:0] C2_LO       = 32'h0000_C280;
   localparam logic [31:0] C2_HI       = 32'h0000_DFBF;
   localparam logic [31:0] C2_MASK     = 32'h0000_E0C0;
   localparam logic [31:0] C2_MATCH    = 32'h0000_C080;
   localparam logic [31:0] SURR_LO     = 32'h00ED_A080;
   localparam logic [31:0] SURR_HI     = 32'h00ED_BFBF;
   localparam logic [31:0] C3_LO       = 32'h00E0_A080;
   localparam logic [31:0] C3_HI       = 32'h00EF_BFBF;
   localparam logic [31:0] C3_MASK     = 32'h00F0_C0C0;
   localparam logic [31:0] C3_MATCH    = 32'h00E0_8080;
   localparam logic [31:0] C4_LO       = 32'hF090_8080;
   localparam logic [31:0] C4_HI       = 32'hF48F_BFBF;
   localparam logic [31:0] C4_MASK     = 32'hF8C0_C0C0;
   localparam logic [31:0] C4_MATCH    = 32'hF080_8080;

   // Byte as held by the decoder, with its lead-byte class (0 = bad lead).
   typedef struct packed {
      logic [7:0] data;
      logic [2:0] lead_len;
   } entry_type;

   // Head of the front queue as seen by the engine.
   typedef struct packed {
      logic      valid;
      logic      is_end;
      entry_type entry;
   } head_type;

   typedef struct packed {
      logic [31:0] packed_char;
      logic [20:0] code_point;
      logic [2:0]  seq_length;
      logic        invalid;
      logic        end_of_text;
      logic        last_of_run;
   } rec_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      if (b < 8'h80) len = 3'd1;
      else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
      else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
      else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
      else len = 3'd0;
      return len;
   endfunction

   function automatic logic word_valid(input logic [31:0] c);
      logic ok;
      if (c <= ASCII_HI) ok = 1'b1;
      else if (c inside {[C2_LO:C2_HI]}) ok = ((c & C2_MASK) == C2_MATCH);
      else if (c inside {[SURR_LO:SURR_HI]}) ok = 1'b0;
      else if (c inside {[C3_LO:C3_HI]}) ok = ((c & C3_MASK) == C3_MATCH);
      else if (c inside {[C4_LO:C4_HI]}) ok = ((c & C4_MASK) == C4_MATCH);
      else ok = 1'b0;
      return ok;
   endfunction

   function automatic logic [20:0] word_decode(input logic [31:0] c);
      logic [31:0] m;
      logic [31:0] d;
      m = (c <= C3_HI) ? 32'h000F_0000 : 32'h003F_0000;
      if (c <= ASCII_HI) d = c;
      else d = ((c & 32'h0700_0000) >> 6) | ((c & m) >> 4) |
               ((c & 32'h0000_3F00) >> 2) | (c & 32'h0000_003F);
      return d[20:0];
   endfunction

endpackage

### rtl/utf8_stream_validating_decoder.sv
// A completing beat reaches the rsp_ ports through the front queue, engine staging register and
// response queue. Throughput: one beat per cycle on valid text while the response queue has room,
// set by the engine's one-byte-per-cycle step. Bytes replayed after a failed sequence pass the
// engine again; a zero byte starts a flush of each pending byte as invalid, then end of text.
// Reset (synchronous, active high) empties both queues and drops any pending sequence.
`include "assert_macros.svh"

module utf8_stream_validating_decoder #(
   parameter int RSP_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_data_byte,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_packed_char,
   output logic [20:0] rsp_code_point,
   output logic [2:0]  rsp_seq_length,
   output logic        rsp_invalid,
   output logic        rsp_end_of_text,
   output logic        rsp_last_of_run
);

   u8vd_pkg::head_type head;
   u8vd_pkg::rec_type  push_rec;
   u8vd_pkg::rec_type  head_rec;
   logic               pop;
   logic               fifo_full;
   logic               fifo_push;
   logic               eot_shape_ok;
   logic               bad_shape_ok;

   u8vd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_full      (req_full),
      .head          (head),
      .pop           (pop)
   );

   u8vd_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_full (fifo_full),
      .rsp_push (fifo_push),
      .rsp_rec  (push_rec)
   );

   u8vd_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .push_rec (push_rec),
      .full     (fifo_full),
      .empty    (rsp_empty),
      .pop      (rsp_pop),
      .head_rec (head_rec)
   );

   assign rsp_packed_char = head_rec.packed_char;
   assign rsp_code_point  = head_rec.code_point;
   assign rsp_seq_length  = head_rec.seq_length;
   assign rsp_invalid     = head_rec.invalid;
   assign rsp_end_of_text = head_rec.end_of_text;
   assign rsp_last_of_run = head_rec.last_of_run;

   assign eot_shape_ok = rsp_last_of_run && (rsp_seq_length == 3'd0) && !rsp_invalid &&
                         (rsp_packed_char == 32'd0);
   assign bad_shape_ok = (rsp_seq_length == 3'd1) && (rsp_packed_char[31:8] == 24'd0) &&
                         (rsp_code_point[20:8] == 13'd0) &&
                         (rsp_code_point[7:0] == rsp_packed_char[7:0]);

   `ASSERT_IMP(a_eot_shape, clock, reset, !rsp_empty && rsp_end_of_text, eot_shape_ok)
   `ASSERT_IMP(a_bad_shape, clock, reset, !rsp_empty && rsp_invalid, bad_shape_ok)
   `ASSERT_IMP(a_len_nonzero, clock, reset, !rsp_empty && !rsp_end_of_text, rsp_seq_length != 3'd0)
   `ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full)

endmodule

### rtl/u8vd_front.sv
module u8vd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_data_byte,
   output logic                req_full,
   output u8vd_pkg::head_type  head,
   input  logic                pop
);

   // Two-entry queue; one-bit pointers wrap naturally.
   typedef struct packed {
      logic                is_end;
      u8vd_pkg::entry_type entry;
   } slot_type;

   slot_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;
   slot_type   new_slot;

   assign req_full = (cnt_ff == 2'd2);
   assign do_push  = req_push && !req_full;
   assign do_pop   = pop && (cnt_ff != 2'd0);

   always_comb begin
      new_slot.is_end         = (req_data_byte == 8'd0);
      new_slot.entry.data     = req_data_byte;
      new_slot.entry.lead_len = u8vd_pkg::lead_len(req_data_byte);
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_comb begin
      head.valid  = (cnt_ff != 2'd0);
      head.is_end = slot_ff[rd_ptr_ff].is_end;
      head.entry  = slot_ff[rd_ptr_ff].entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= new_slot;
      end
   end

endmodule

### rtl/u8vd_engine.sv
module u8vd_engine (
   input  logic               clock,
   input  logic               reset,
   input  u8vd_pkg::head_type head,
   output logic               pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output u8vd_pkg::rec_type  rsp_rec
);

   typedef enum logic [4:0] {
      ACT_NONE        = 5'b00001,
      ACT_STEP        = 5'b00010,
      ACT_FLUSH_BAD   = 5'b00100,
      ACT_EOT         = 5'b01000,
      ACT_START_FLUSH = 5'b10000
   } act_type;

   // Window: pending bytes first, then bytes still to be replayed.
   u8vd_pkg::entry_type buf_ff [4];
   u8vd_pkg::entry_type buf_in [4];
   u8vd_pkg::entry_type v [4];
   logic [2:0] cnt_ff, cnt_in;     // bytes in the window
   logic [1:0] pend_ff, pend_in;   // bytes of the window already collected
   logic [2:0] exp_ff, exp_in;
   logic       flush_ff, flush_in;
   u8vd_pkg::rec_type stg_ff, stg_in;
   logic       stg_vld_ff, stg_vld_in;
   logic       stg_fin_ff, stg_fin_in;

   act_type    act;
   logic       go, from_queue, new_res, run_end;
   logic [2:0] v_cnt, np, exp_n, shift, idx;
   logic [31:0] w;
   u8vd_pkg::rec_type res;

   assign go = !rsp_full;

   always_comb begin
      act        = ACT_NONE;
      from_queue = 1'b0;
      if (cnt_ff > {1'b0, pend_ff}) begin
         act = ACT_STEP;
      end else if (flush_ff) begin
         act = (cnt_ff != 3'd0) ? ACT_FLUSH_BAD : ACT_EOT;
      end else if (head.valid) begin
         from_queue = 1'b1;
         act        = head.is_end ? ACT_START_FLUSH : ACT_STEP;
      end
   end

   assign pop = go && from_queue;

   always_comb begin
      v     = buf_ff;
      v_cnt = cnt_ff;
      if (from_queue && !head.is_end) begin
         v[cnt_ff[1:0]] = head.entry;
         v_cnt          = cnt_ff + 3'd1;
      end

      res.packed_char = {24'd0, v[0].data};
      res.code_point  = {13'd0, v[0].data};
      res.seq_length  = 3'd1;
      res.invalid     = 1'b1;
      res.end_of_text = 1'b0;
      res.last_of_run = 1'b0;

      new_res  = 1'b0;
      run_end  = 1'b0;
      shift    = 3'd0;
      pend_in  = pend_ff;
      exp_in   = exp_ff;
      flush_in = flush_ff;
      np       = {1'b0, pend_ff} + 3'd1;
      exp_n    = (pend_ff == 2'd0) ? v[0].lead_len : exp_ff;

      case (v_cnt[2:0])
         3'd1:    w = {24'd0, v[0].data};
         3'd2:    w = {16'd0, v[0].data, v[1].data};
         3'd3:    w = {8'd0, v[0].data, v[1].data, v[2].data};
         default: w = {v[0].data, v[1].data, v[2].data, v[3].data};
      endcase
      // the word spans exactly the expected length
      case (exp_n)
         3'd1:    w = {24'd0, v[0].data};
         3'd2:    w = {16'd0, v[0].data, v[1].data};
         3'd3:    w = {8'd0, v[0].data, v[1].data, v[2].data};
         default: w = {v[0].data, v[1].data, v[2].data, v[3].data};
      endcase

      case (act)
         ACT_STEP: begin
            if (exp_n == 3'd0) begin
               // bad lead byte
               new_res = 1'b1;
               shift   = 3'd1;
               pend_in = 2'd0;
            end else if (np >= exp_n) begin
               exp_in  = exp_n;
               new_res = 1'b1;
               pend_in = 2'd0;
               if (u8vd_pkg::word_valid(w)) begin
                  res.packed_char = w;
                  res.code_point  = u8vd_pkg::word_decode(w);
                  res.seq_length  = exp_n;
                  res.invalid     = 1'b0;
                  shift           = exp_n;
               end else begin
                  shift = 3'd1;    // lead out, the rest is replayed
               end
            end else begin
               exp_in  = exp_n;
               pend_in = np[1:0];
            end
         end
         ACT_FLUSH_BAD: begin
            new_res = 1'b1;
            shift   = 3'd1;
            pend_in = 2'd0;
         end
         ACT_EOT: begin
            new_res         = 1'b1;
            res.packed_char = 32'd0;
            res.code_point  = 21'd0;
            res.seq_length  = 3'd0;
            res.invalid     = 1'b0;
            res.end_of_text = 1'b1;
            flush_in        = 1'b0;
            run_end         = 1'b1;
         end
         ACT_START_FLUSH: begin
            flush_in = 1'b1;
         end
         default: begin
         end
      endcase

      cnt_in = v_cnt - shift;
      if (act == ACT_STEP && !flush_ff && cnt_in == {1'b0, pend_in}) begin
         run_end = 1'b1;
      end

      for (int i = 0; i < 4; i++) begin
         idx       = 3'(i) + shift;
         buf_in[i] = (idx < 3'd4) ? v[idx[1:0]] : v[i];
      end
   end

   // Staging register: a result is known to close its run only later.
   always_comb begin
      rsp_push             = go && stg_vld_ff && (stg_fin_ff || new_res);
      rsp_rec              = stg_ff;
      rsp_rec.last_of_run  = stg_fin_ff;
      stg_in               = new_res ? res : stg_ff;
      if (new_res) begin
         stg_vld_in = 1'b1;
         stg_fin_in = run_end;
      end else if (rsp_push) begin
         stg_vld_in = 1'b0;
         stg_fin_in = 1'b0;
      end else begin
         stg_vld_in = stg_vld_ff;
         stg_fin_in = stg_fin_ff || run_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= 3'd0;
         pend_ff    <= 2'd0;
         exp_ff     <= 3'd0;
         flush_ff   <= 1'b0;
         stg_vld_ff <= 1'b0;
         stg_fin_ff <= 1'b0;
      end else if (go) begin
         cnt_ff     <= cnt_in;
         pend_ff    <= pend_in;
         exp_ff     <= exp_in;
         flush_ff   <= flush_in;
         stg_vld_ff <= stg_vld_in;
         stg_fin_ff <= stg_fin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         buf_ff <= buf_in;
         stg_ff <= stg_in;
      end
   end

endmodule

### rtl/u8vd_rsp_fifo.sv
module u8vd_rsp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u8vd_pkg::rec_type push_rec,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output u8vd_pkg::rec_type head_rec
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   u8vd_pkg::rec_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_rec = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule
